/* design/rmfh_pkg.sv */
package rmfh_pkg;

    localparam int ID_W           = 6;
    localparam int STATUS_W       = 3;
    localparam int NUM_PROCS_DEF  = 64;
    localparam int COUNT_BITS_DEF = 16;

    typedef enum logic [0:0] {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED     = 3'd0,
        ST_REGRANTED   = 3'd1,
        ST_QUEUED      = 3'd2,
        ST_UNLOCKED    = 3'd3,
        ST_DECREMENTED = 3'd4,
        ST_HANDED      = 3'd5,
        ST_NOT_OWNER   = 3'd6,
        ST_FULL        = 3'd7
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch request, read queue head
        logic exec;   // apply the request, launch the result
    } t_cmd;

endpackage

/* design/rmfh_ctrl.sv */
module rmfh_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output rmfh_pkg::t_cmd   o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule

/* design/rmfh_dp.sv */
module rmfh_dp #(
    parameter int NUM_PROCS  = rmfh_pkg::NUM_PROCS_DEF,
    parameter int COUNT_BITS = rmfh_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rmfh_pkg::t_cmd                i_cmd,
    input  logic                          i_opcode,
    input  logic [rmfh_pkg::ID_W-1:0]     i_requester_id,
    output logic                          o_valid,
    output logic [rmfh_pkg::STATUS_W-1:0] o_status,
    output logic [rmfh_pkg::ID_W-1:0]     o_new_owner_id,
    output logic                          o_owner_valid
);

    localparam int PTR_W  = $clog2(NUM_PROCS);
    localparam int FILL_W = $clog2(NUM_PROCS + 1);
    localparam logic [PTR_W-1:0]      PTR_LAST  = PTR_W'(NUM_PROCS - 1);
    localparam logic [FILL_W-1:0]     FILL_FULL = FILL_W'(NUM_PROCS);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // wait queue storage
    logic [rmfh_pkg::ID_W-1:0] r_mem [NUM_PROCS];
    logic [rmfh_pkg::ID_W-1:0] r_head_id;

    // latched request
    rmfh_pkg::t_op             r_op;
    logic [rmfh_pkg::ID_W-1:0] r_id;

    // lock state
    logic                      r_held, n_held;
    logic [rmfh_pkg::ID_W-1:0] r_owner, n_owner;
    logic [COUNT_BITS-1:0]     r_count, n_count;
    logic [PTR_W-1:0]          r_head, n_head;
    logic [PTR_W-1:0]          r_tail, n_tail;
    logic [FILL_W-1:0]         r_fill, n_fill;
    logic                      n_push;
    rmfh_pkg::t_status         n_status;

    // result registers
    logic                          r_out_valid;
    logic [rmfh_pkg::STATUS_W-1:0] r_out_status;
    logic [rmfh_pkg::ID_W-1:0]     r_out_owner;
    logic                          r_out_held;

    always_comb begin
        n_held   = r_held;
        n_owner  = r_owner;
        n_count  = r_count;
        n_head   = r_head;
        n_tail   = r_tail;
        n_fill   = r_fill;
        n_push   = 1'b0;
        n_status = rmfh_pkg::ST_NOT_OWNER;
        case (r_op)
            rmfh_pkg::OP_ACQUIRE: begin
                if (!r_held) begin
                    n_held   = 1'b1;
                    n_owner  = r_id;
                    n_count  = '0;
                    n_status = rmfh_pkg::ST_GRANTED;
                end else if (r_owner == r_id) begin
                    if (r_count == COUNT_MAX) begin
                        n_status = rmfh_pkg::ST_FULL;
                    end else begin
                        n_count  = r_count + 1'b1;
                        n_status = rmfh_pkg::ST_REGRANTED;
                    end
                end else if (r_fill == FILL_FULL) begin
                    n_status = rmfh_pkg::ST_FULL;
                end else begin
                    n_push   = 1'b1;
                    n_tail   = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                    n_fill   = r_fill + 1'b1;
                    n_status = rmfh_pkg::ST_QUEUED;
                end
            end
            rmfh_pkg::OP_RELEASE: begin
                if (!r_held || (r_owner != r_id)) begin
                    n_status = rmfh_pkg::ST_NOT_OWNER;
                end else if (r_count != '0) begin
                    n_count  = r_count - 1'b1;
                    n_status = rmfh_pkg::ST_DECREMENTED;
                end else if (r_fill != '0) begin
                    n_owner  = r_head_id;
                    n_head   = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                    n_fill   = r_fill - 1'b1;
                    n_count  = '0;
                    n_status = rmfh_pkg::ST_HANDED;
                end else begin
                    n_held   = 1'b0;
                    n_owner  = '0;
                    n_status = rmfh_pkg::ST_UNLOCKED;
                end
            end
            default: begin
                n_status = rmfh_pkg::ST_NOT_OWNER;
            end
        endcase
    end

    // queue memory: one write port at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && n_push) begin
            r_mem[r_tail] <= r_id;
        end
        if (i_cmd.load) begin
            r_head_id <= r_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= rmfh_pkg::t_op'(i_opcode);
            r_id <= i_requester_id;
        end
        if (i_cmd.exec) begin
            r_out_status <= n_status;
            r_out_owner  <= n_held ? n_owner : '0;
            r_out_held   <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_owner     <= '0;
            r_count     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_held  <= n_held;
                r_owner <= n_owner;
                r_count <= n_count;
                r_head  <= n_head;
                r_tail  <= n_tail;
                r_fill  <= n_fill;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_new_owner_id = r_out_owner;
    assign o_owner_valid  = r_out_held;

endmodule

/* design/recursive_mutex_fifo_handoff_top.sv */
// Lock manager for one recursive mutex with a FIFO wait queue. A request
// (acquire or release plus requester id) is taken when start is high and
// busy is low; busy then stays high for one cycle while the queue head is
// read from the wait-queue memory and the lock state is updated. The result
// appears on o_status / o_new_owner_id / o_owner_valid for exactly one cycle
// with o_valid high, in the cycle right after busy falls. There is no way to
// hold it off: capture it when o_valid is seen. No new request is taken while
// busy is high.
// Status 7 covers both a full wait queue and a saturated recursion count.
module recursive_mutex_fifo_handoff_top #(
    parameter int NUM_PROCS  = rmfh_pkg::NUM_PROCS_DEF,
    parameter int COUNT_BITS = rmfh_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [rmfh_pkg::ID_W-1:0]     i_requester_id,
    output logic                          o_valid,
    output logic [rmfh_pkg::STATUS_W-1:0] o_status,
    output logic [rmfh_pkg::ID_W-1:0]     o_new_owner_id,
    output logic                          o_owner_valid
);

    rmfh_pkg::t_cmd cmd;

    rmfh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    rmfh_dp #(
        .NUM_PROCS  (NUM_PROCS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_opcode       (i_opcode),
        .i_requester_id (i_requester_id),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_new_owner_id (o_new_owner_id),
        .o_owner_valid  (o_owner_valid)
    );

endmodule

/* design/rmfh_chk.sv */
module rmfh_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_valid,
    input logic [rmfh_pkg::STATUS_W-1:0] o_status,
    input logic [rmfh_pkg::ID_W-1:0]     o_new_owner_id,
    input logic                          o_owner_valid
);

    // an accepted item is followed by busy, then by its result
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("result missing two cycles after accept");

    // free lock reports owner zero
    a_free_owner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_owner_valid) |-> (o_new_owner_id == '0))
        else $error("nonzero owner on a free lock");

    a_grant_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_status == rmfh_pkg::ST_GRANTED) ||
                     (o_status == rmfh_pkg::ST_HANDED) ||
                     (o_status == rmfh_pkg::ST_REGRANTED))) |-> o_owner_valid)
        else $error("lock not held after grant");

    a_unlock_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == rmfh_pkg::ST_UNLOCKED)) |-> !o_owner_valid)
        else $error("lock still held after unlock");

endmodule

bind recursive_mutex_fifo_handoff_top rmfh_chk u_chk (.*);

/* tb/recursive_mutex_fifo_handoff_top_tb.sv */
module recursive_mutex_fifo_handoff_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W        = rmfh_pkg::ID_W;
    localparam int STATUS_W    = rmfh_pkg::STATUS_W;
    localparam int NUM_PROCS   = rmfh_pkg::NUM_PROCS_DEF;
    localparam int COUNT_BITS  = rmfh_pkg::COUNT_BITS_DEF;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam int STALL_LIMIT = 2000;
    localparam int NEST_DEPTH  = 40;

    typedef struct packed {
        rmfh_pkg::t_status  status;
        logic [ID_W-1:0]    owner;
        logic               held;
    } t_lock_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_opcode;
    logic [ID_W-1:0]     i_requester_id;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_new_owner_id;
    logic                o_owner_valid;

    // lock state as the testbench believes it to be
    bit                    lock_held;
    logic [ID_W-1:0]       lock_owner;
    logic [COUNT_BITS-1:0] nest_count;
    logic [ID_W-1:0]       waiters[$];

    t_lock_result pending_results[$];

    bit          sender_idles = 1'b1;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    int unsigned status_seen[8];

    recursive_mutex_fifo_handoff_top #(
        .NUM_PROCS  (NUM_PROCS),
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_requester_id (i_requester_id),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_new_owner_id (o_new_owner_id),
        .o_owner_valid  (o_owner_valid)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_lock_result apply_request(input rmfh_pkg::t_op op,
                                                   input logic [ID_W-1:0] who);
        t_lock_result r;
        if (op == rmfh_pkg::OP_ACQUIRE) begin
            if (!lock_held) begin
                lock_held  = 1'b1;
                lock_owner = who;
                nest_count = '0;
                r.status   = rmfh_pkg::ST_GRANTED;
            end else if (lock_owner == who) begin
                if (nest_count == COUNT_MAX) begin
                    r.status = rmfh_pkg::ST_FULL;
                end else begin
                    nest_count++;
                    r.status = rmfh_pkg::ST_REGRANTED;
                end
            end else if (waiters.size() >= NUM_PROCS) begin
                r.status = rmfh_pkg::ST_FULL;
            end else begin
                waiters.push_back(who);
                r.status = rmfh_pkg::ST_QUEUED;
            end
        end else begin
            if (!lock_held || lock_owner != who) begin
                r.status = rmfh_pkg::ST_NOT_OWNER;
            end else if (nest_count != '0) begin
                nest_count--;
                r.status = rmfh_pkg::ST_DECREMENTED;
            end else if (waiters.size() != 0) begin
                lock_owner = waiters.pop_front();
                nest_count = '0;
                r.status   = rmfh_pkg::ST_HANDED;
            end else begin
                lock_held  = 1'b0;
                lock_owner = '0;
                r.status   = rmfh_pkg::ST_UNLOCKED;
            end
        end
        r.held  = lock_held;
        r.owner = lock_held ? lock_owner : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // start is left high after acceptance so back-to-back items need no extra edge
    task automatic issue_request(input rmfh_pkg::t_op op, input logic [ID_W-1:0] who);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(0, 99) < 35)
            gap = $urandom_range(1, 4);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_opcode       <= op;
        i_requester_id <= who;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(apply_request(op, who));
        items_sent++;
    endtask

    task automatic settle_lock();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_lock_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding, status %0d",
                                          o_status));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                status_seen[want.status]++;
                if (o_status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d (%s)",
                                              o_status, want.status, want.status.name()));
                if (o_new_owner_id !== want.owner)
                    report_mismatch($sformatf("new_owner_id got %0d want %0d (%s)",
                                              o_new_owner_id, want.owner,
                                              want.status.name()));
                if (o_owner_valid !== want.held)
                    report_mismatch($sformatf("owner_valid got %0b want %0b (%s)",
                                              o_owner_valid, want.held, want.status.name()));
            end
        end else if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            report_mismatch("o_valid unknown");
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_grant_and_release();
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd0);
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd0);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd0);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd63);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd0);
        // release of a free lock
        issue_request(rmfh_pkg::OP_RELEASE, 6'd0);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd21);
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd63);
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd63);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd42);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd63);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd63);
        settle_lock();
    endtask

    task automatic test_handoff_order();
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd10);
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd20);
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd30);
        // same waiter twice gets two turns
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd20);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd20);
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd10);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd10);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd10);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd20);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd30);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd20);
        settle_lock();
    endtask

    task automatic test_queue_full();
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd1);
        for (int k = 0; k < NUM_PROCS; k++)
            issue_request(rmfh_pkg::OP_ACQUIRE, (k == 1) ? 6'd0 : 6'(k));
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd2);
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd63);
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd1);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd1);
        // walk the lock through every waiter, pointers wrap on the way
        for (int k = 0; k <= NUM_PROCS; k++)
            issue_request(rmfh_pkg::OP_RELEASE, lock_owner);
        settle_lock();
    endtask

    task automatic test_deep_nesting();
        sender_idles = 1'b0;
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd42);
        for (int k = 0; k < NEST_DEPTH; k++)
            issue_request(rmfh_pkg::OP_ACQUIRE, 6'd42);
        issue_request(rmfh_pkg::OP_ACQUIRE, 6'd9);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd9);
        for (int k = 0; k < NEST_DEPTH; k++)
            issue_request(rmfh_pkg::OP_RELEASE, 6'd42);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd42);
        issue_request(rmfh_pkg::OP_RELEASE, 6'd9);
        sender_idles = 1'b1;
        settle_lock();
    endtask

    task automatic test_random_traffic(input int n_items);
        int              left;
        int              acq_pct;
        int              own_pct;
        int              pick;
        rmfh_pkg::t_op   op;
        logic [ID_W-1:0] who;
        left    = 0;
        acq_pct = 50;
        own_pct = 55;
        for (int k = 0; k < n_items; k++) begin
            if (left == 0) begin
                left = $urandom_range(20, 80);
                case ($urandom_range(0, 3))
                    0: begin acq_pct = 20;  own_pct = 70; end
                    1: begin acq_pct = 50;  own_pct = 55; end
                    2: begin acq_pct = 75;  own_pct = 40; end
                    default: begin
                        // flood the wait queue
                        acq_pct = 100;
                        own_pct = 10;
                        left    = 90;
                    end
                endcase
            end
            left--;
            sender_idles = !(k >= n_items / 3 && k < n_items / 2);
            if ($urandom_range(0, 99) < 10) begin
                op  = rmfh_pkg::t_op'($urandom_range(0, 1));
                who = ID_W'($urandom_range(0, 63));
            end else begin
                op   = ($urandom_range(0, 99) < acq_pct) ? rmfh_pkg::OP_ACQUIRE
                                                         : rmfh_pkg::OP_RELEASE;
                pick = $urandom_range(0, 99);
                if (lock_held && pick < own_pct)
                    who = lock_owner;
                else if (pick < own_pct + 20 && waiters.size() != 0)
                    who = waiters[$urandom_range(0, waiters.size() - 1)];
                else
                    who = ID_W'($urandom_range(0, 63));
            end
            issue_request(op, who);
        end
        sender_idles = 1'b1;
        settle_lock();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_opcode       <= rmfh_pkg::OP_ACQUIRE;
        i_requester_id <= '0;
        lock_held  = 1'b0;
        lock_owner = '0;
        nest_count = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_grant_and_release();
        test_handoff_order();
        test_queue_full();
        test_deep_nesting();
        test_random_traffic(500);

        $display("covered grants, nesting, hand-over order, a full queue with wrap, %0d items",
                 items_sent);
        $display("results checked %0d (queued %0d, handed %0d, full %0d), mismatches %0d",
                 results_checked, status_seen[rmfh_pkg::ST_QUEUED],
                 status_seen[rmfh_pkg::ST_HANDED], status_seen[rmfh_pkg::ST_FULL],
                 mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* recursive_mutex_fifo_handoff_top.f */
design/rmfh_pkg.sv
design/rmfh_ctrl.sv
design/rmfh_dp.sv
design/recursive_mutex_fifo_handoff_top.sv
design/rmfh_chk.sv
tb/recursive_mutex_fifo_handoff_top_tb.sv
